[sv/rwli_pkg.sv]
`timescale 1ns / 1ps

package rwli_pkg;

    // Fixed field widths of the transaction payloads.
    localparam int SAMPLE_W   = 8;
    localparam int OFFSET_W   = 16;
    localparam int CHANNEL_W  = 3;
    localparam int POSITION_W = 7;
    localparam int COUNT_W    = 4;
    localparam int WIDTH_W    = 8;
    localparam int PROD_W     = 17;

    // Defaults for the top-level parameters.
    localparam int MAX_CHANNELS_DEF = 8;
    localparam int MAX_WIDTH_DEF    = 128;

    // A warp never emits more results than this.
    localparam int RESULT_LIMIT = 8;

    // Configuration register indexes.
    typedef enum logic [0:0] {
        CFG_CHANNEL_COUNT = 1'b0,
        CFG_ROW_WIDTH     = 1'b1
    } cfg_index_t;

    // Item modes.
    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_WARP = 1'b1;

    // Control from the sequencer to the interpolation unit.
    typedef struct packed {
        logic load_right;
        logic load_prod;
        logic right_ok;
        logic left_ok;
    } interp_ctrl_t;

endpackage

[sv/rwli_row_mem.sv]
`timescale 1ns / 1ps

module rwli_row_mem #(
    parameter int DEPTH = rwli_pkg::MAX_CHANNELS_DEF * rwli_pkg::MAX_WIDTH_DEF
) (
    input  logic                                 aclk,
    input  logic                                 wr_en,
    input  logic [$clog2(DEPTH)-1:0]             wr_addr,
    input  logic signed [rwli_pkg::SAMPLE_W-1:0] wr_data,
    input  logic                                 rd_en,
    input  logic [$clog2(DEPTH)-1:0]             rd_addr,
    output logic signed [rwli_pkg::SAMPLE_W-1:0] rd_data
);
    import rwli_pkg::*;

    logic signed [SAMPLE_W-1:0] mem [DEPTH];

    // Single write port and one registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[sv/rwli_interp.sv]
`timescale 1ns / 1ps

module rwli_interp (
    input  logic                                 aclk,
    input  rwli_pkg::interp_ctrl_t               ctrl,
    input  logic signed [rwli_pkg::SAMPLE_W-1:0] rd_data,
    input  logic signed [rwli_pkg::SAMPLE_W-1:0] frac,
    output logic signed [rwli_pkg::SAMPLE_W-1:0] value
);
    import rwli_pkg::*;

    logic signed [SAMPLE_W-1:0] right_reg;
    logic signed [SAMPLE_W-1:0] right_next;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [PROD_W-1:0]   prod_next;
    logic signed [SAMPLE_W-1:0] left_smp;
    logic signed [SAMPLE_W:0]   diff;

    // Out-of-row indices read as zero.
    always_comb begin
        left_smp   = ctrl.left_ok ? rd_data : '0;
        right_next = ctrl.right_ok ? rd_data : '0;
        diff       = {left_smp[SAMPLE_W-1], left_smp} - {right_reg[SAMPLE_W-1], right_reg};
        prod_next  = diff * frac;
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load_right) begin
            right_reg <= right_next;
        end
        if (ctrl.load_prod) begin
            prod_reg <= prod_next;
        end
    end

    // The right sample sits in the high byte, so only bits 15:8 of the product add to it.
    assign value = right_reg + prod_reg[2*SAMPLE_W-1:SAMPLE_W];

endmodule

[sv/row_warp_linear_interp.sv]
`timescale 1ns / 1ps

// Channel   Handshake         Payload
// s_        s_valid/s_ready   s_mode, s_channel, s_position, s_sample, s_offset
// m_        m_valid/m_ready   m_out_channel, m_out_position, m_value, m_last
// cfg_      cfg_wr_en         cfg_index, cfg_data
//
// A load transaction is taken only while the block is idle and writes the row store at once.
// For each channel a warp transaction makes two reads on the single read port of the row
// store, right then left, then takes one multiply stage and one output step.
// The block is not ready while a warp is in progress; a finished result waits in
// the output register while the next input transaction is taken.
// Reset is synchronous and active low; the row store is not cleared.
// A stalled output holds the sequencer in its output step until the result is taken.
module row_warp_linear_interp #(
    parameter int MAX_CHANNELS = rwli_pkg::MAX_CHANNELS_DEF,
    parameter int MAX_WIDTH    = rwli_pkg::MAX_WIDTH_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic                                   s_mode,
    input  logic [rwli_pkg::CHANNEL_W-1:0]         s_channel,
    input  logic [rwli_pkg::POSITION_W-1:0]        s_position,
    input  logic signed [rwli_pkg::SAMPLE_W-1:0]   s_sample,
    input  logic signed [rwli_pkg::OFFSET_W-1:0]   s_offset,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic [rwli_pkg::CHANNEL_W-1:0]         m_out_channel,
    output logic [rwli_pkg::POSITION_W-1:0]        m_out_position,
    output logic signed [rwli_pkg::SAMPLE_W-1:0]   m_value,
    output logic                                   m_last,
    input  logic                                   cfg_wr_en,
    input  rwli_pkg::cfg_index_t                   cfg_index,
    input  logic [rwli_pkg::WIDTH_W-1:0]           cfg_data
);
    import rwli_pkg::*;

    localparam int DEPTH     = MAX_CHANNELS * MAX_WIDTH;
    localparam int ADDR_W    = $clog2(DEPTH);
    localparam int CH_LIMIT  = (MAX_CHANNELS < RESULT_LIMIT) ? MAX_CHANNELS : RESULT_LIMIT;

    typedef enum logic [4:0] {
        ST_IDLE     = 5'b00001,
        ST_RD_RIGHT = 5'b00010,
        ST_RD_LEFT  = 5'b00100,
        ST_MUL      = 5'b01000,
        ST_EMIT     = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic [COUNT_W-1:0]    channel_count_reg;
    logic [WIDTH_W-1:0]    row_width_reg;
    logic [COUNT_W-1:0]    n_count;

    logic [CHANNEL_W-1:0]  chan_reg, chan_next;
    logic [POSITION_W-1:0] pos_reg, pos_next;
    logic [SAMPLE_W-1:0]   rcol_reg, rcol_next;
    logic [SAMPLE_W-1:0]   lcol_reg, lcol_next;
    logic signed [SAMPLE_W-1:0] frac_reg, frac_next;

    logic                  m_valid_reg;
    logic [CHANNEL_W-1:0]  out_chan_reg;
    logic [POSITION_W-1:0] out_pos_reg;
    logic signed [SAMPLE_W-1:0] out_value_reg;
    logic                  out_last_reg;

    logic                  accept;
    logic                  load_wr;
    logic [31:0]           wr_addr_full;
    logic [31:0]           rd_addr_full;
    logic [SAMPLE_W-1:0]   rd_idx;
    logic                  rd_en;
    logic signed [SAMPLE_W-1:0] rd_data;
    logic                  right_ok, left_ok;
    logic                  is_last;
    logic                  emit_go;
    logic signed [SAMPLE_W-1:0] interp_value;
    interp_ctrl_t          ictrl;

    // An index is in the row when it is non-negative and below both limits.
    function automatic logic idx_in_row(input logic [SAMPLE_W-1:0] idx,
                                        input logic [WIDTH_W-1:0] width);
        logic ok;
        ok = !idx[SAMPLE_W-1]
             && ({1'b0, idx[SAMPLE_W-2:0]} < width)
             && (32'(idx[SAMPLE_W-2:0]) < 32'(MAX_WIDTH));
        return ok;
    endfunction

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            channel_count_reg <= COUNT_W'(1);
            row_width_reg     <= WIDTH_W'(128);
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_CHANNEL_COUNT: channel_count_reg <= cfg_data[COUNT_W-1:0];
                CFG_ROW_WIDTH:     row_width_reg     <= cfg_data;
                default:           ;
            endcase
        end
    end

    // Channels per warp, saturated at the store's channel count and the result limit.
    assign n_count = (32'(channel_count_reg) > 32'(CH_LIMIT)) ? COUNT_W'(CH_LIMIT)
                                                              : channel_count_reg;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;

    // Load path: out-of-range channels or columns are dropped.
    assign load_wr = accept && (s_mode == MODE_LOAD)
                     && (32'(s_channel) < 32'(MAX_CHANNELS))
                     && (32'(s_position) < 32'(MAX_WIDTH));
    assign wr_addr_full = 32'(s_channel) * 32'(MAX_WIDTH) + 32'(s_position);

    // Read path: right index first, then left, for the current channel.
    assign rd_idx       = (state_reg == ST_RD_RIGHT) ? rcol_reg : lcol_reg;
    assign rd_en        = (state_reg == ST_RD_RIGHT) || (state_reg == ST_RD_LEFT);
    assign rd_addr_full = 32'(chan_reg) * 32'(MAX_WIDTH) + 32'(rd_idx[SAMPLE_W-2:0]);
    assign right_ok     = idx_in_row(rcol_reg, row_width_reg);
    assign left_ok      = idx_in_row(lcol_reg, row_width_reg);

    rwli_row_mem #(
        .DEPTH (DEPTH)
    ) u_row_mem (
        .aclk    (aclk),
        .wr_en   (load_wr),
        .wr_addr (wr_addr_full[ADDR_W-1:0]),
        .wr_data (s_sample),
        .rd_en   (rd_en),
        .rd_addr (rd_addr_full[ADDR_W-1:0]),
        .rd_data (rd_data)
    );

    assign ictrl.load_right = (state_reg == ST_RD_LEFT);
    assign ictrl.load_prod  = (state_reg == ST_MUL);
    assign ictrl.right_ok   = right_ok;
    assign ictrl.left_ok    = left_ok;

    rwli_interp u_interp (
        .aclk    (aclk),
        .ctrl    (ictrl),
        .rd_data (rd_data),
        .frac    (frac_reg),
        .value   (interp_value)
    );

    assign is_last = ((COUNT_W'(chan_reg) + COUNT_W'(1)) == n_count);
    assign emit_go = (state_reg == ST_EMIT) && (!m_valid_reg || m_ready);

    // Sequencer over the channels of one warp.
    always_comb begin
        state_next = state_reg;
        chan_next  = chan_reg;
        pos_next   = pos_reg;
        rcol_next  = rcol_reg;
        lcol_next  = lcol_reg;
        frac_next  = frac_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept && (s_mode == MODE_WARP)) begin
                    chan_next = '0;
                    pos_next  = s_position;
                    rcol_next = {1'b0, s_position} - s_offset[OFFSET_W-1:SAMPLE_W];
                    lcol_next = rcol_next - SAMPLE_W'(1);
                    frac_next = s_offset[SAMPLE_W-1:0];
                    if (n_count != '0) begin
                        state_next = ST_RD_RIGHT;
                    end
                end
            end
            ST_RD_RIGHT: state_next = ST_RD_LEFT;
            ST_RD_LEFT:  state_next = ST_MUL;
            ST_MUL:      state_next = ST_EMIT;
            ST_EMIT: begin
                if (emit_go) begin
                    if (is_last) begin
                        state_next = ST_IDLE;
                    end else begin
                        chan_next  = chan_reg + CHANNEL_W'(1);
                        state_next = ST_RD_RIGHT;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
        chan_reg <= chan_next;
        pos_reg  <= pos_next;
        rcol_reg <= rcol_next;
        lcol_reg <= lcol_next;
        frac_reg <= frac_next;
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (emit_go) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (emit_go) begin
            out_chan_reg  <= chan_reg;
            out_pos_reg   <= pos_reg;
            out_value_reg <= interp_value;
            out_last_reg  <= is_last;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_out_channel  = out_chan_reg;
    assign m_out_position = out_pos_reg;
    assign m_value        = out_value_reg;
    assign m_last         = out_last_reg;

    // A warp with channels to emit makes the block busy on the next cycle.
    a_warp_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && (s_mode == MODE_WARP) && (n_count != '0) |=> !s_ready)
        else $error("warp transaction did not occupy the sequencer");

    // The last flag marks the final channel of the request.
    a_last_channel: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_last |-> ((COUNT_W'(m_out_channel) + COUNT_W'(1)) == n_count))
        else $error("last flag on a channel other than the final one");

    // A full, stalled output register holds the sequencer in its output step.
    a_emit_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT) && m_valid_reg && !m_ready |=> (state_reg == ST_EMIT))
        else $error("result step left while the output register was full");

endmodule

[test/row_warp_linear_interp_tb.sv]
`timescale 1ns / 1ps

module row_warp_linear_interp_tb;

    import rwli_pkg::*;

    localparam int SETTLE_CYCLES   = 4 * RESULT_LIMIT + 16;
    localparam int HOLD_CYCLES     = 300;
    localparam int RANDOM_PHASES   = 5;
    localparam int ITEMS_PER_PHASE = 30;
    localparam int TIMEOUT_NS      = 2_000_000;

    // One interpolated sample as it leaves the block.
    typedef struct packed {
        logic [CHANNEL_W-1:0]         chan;
        logic [POSITION_W-1:0]        pos;
        logic signed [SAMPLE_W-1:0]   value;
        logic                         last;
    } interp_result_t;

    logic                          aclk;
    logic                          aresetn;
    logic                          s_valid;
    logic                          s_ready;
    logic                          s_mode;
    logic [CHANNEL_W-1:0]          s_channel;
    logic [POSITION_W-1:0]         s_position;
    logic signed [SAMPLE_W-1:0]    s_sample;
    logic signed [OFFSET_W-1:0]    s_offset;
    logic                          m_valid;
    logic                          m_ready;
    logic [CHANNEL_W-1:0]          m_out_channel;
    logic [POSITION_W-1:0]         m_out_position;
    logic signed [SAMPLE_W-1:0]    m_value;
    logic                          m_last;
    logic                          cfg_wr_en;
    cfg_index_t                    cfg_index;
    logic [WIDTH_W-1:0]            cfg_data;

    // Shadow copy of the row store and the two registers.
    logic signed [SAMPLE_W-1:0]    row_mem [MAX_CHANNELS_DEF][MAX_WIDTH_DEF];
    bit                            row_written [MAX_CHANNELS_DEF][MAX_WIDTH_DEF];
    int                            chan_cfg;
    int                            width_cfg;

    interp_result_t                pending_results[$];
    interp_result_t                want;

    int burst_left;
    int items_sent;
    int warps_sent;
    int cfg_writes;
    int results_seen;
    int error_count;
    int hold_request;
    int hold_served;

    row_warp_linear_interp dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_mode         (s_mode),
        .s_channel      (s_channel),
        .s_position     (s_position),
        .s_sample       (s_sample),
        .s_offset       (s_offset),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_channel  (m_out_channel),
        .m_out_position (m_out_position),
        .m_value        (m_value),
        .m_last         (m_last),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always #2 aclk = ~aclk;

    // Channels emitted per warp after saturation.
    function automatic int active_count();
        return (chan_cfg > RESULT_LIMIT) ? RESULT_LIMIT : chan_cfg;
    endfunction

    // True when an index points at a stored sample rather than reading zero.
    function automatic bit in_row(input logic signed [SAMPLE_W-1:0] idx);
        int limit;
        limit = (width_cfg < MAX_WIDTH_DEF) ? width_cfg : MAX_WIDTH_DEF;
        return (idx >= 0) && (int'(idx) < limit);
    endfunction

    // Right index is position minus the signed shift, left is one less, both 8-bit wrapped.
    function automatic void warp_indices(input logic [POSITION_W-1:0] pos,
                                         input logic [OFFSET_W-1:0] off,
                                         output logic signed [SAMPLE_W-1:0] rcol,
                                         output logic signed [SAMPLE_W-1:0] lcol);
        logic signed [SAMPLE_W-1:0] shift;
        shift = off[15:8];
        rcol = $signed({1'b0, pos}) - shift;
        lcol = rcol - 8'sd1;
    endfunction

    // Applies one transaction to the shadow state and queues the samples it yields.
    function automatic void interpolate_item(input logic mode, input logic [CHANNEL_W-1:0] chan,
                                             input logic [POSITION_W-1:0] pos,
                                             input logic signed [SAMPLE_W-1:0] smp,
                                             input logic [OFFSET_W-1:0] off);
        logic signed [SAMPLE_W-1:0] rcol;
        logic signed [SAMPLE_W-1:0] lcol;
        int rv;
        int lv;
        int fv;
        int total;
        int n;
        interp_result_t res;
        if (mode == MODE_LOAD) begin
            row_mem[chan][pos] = smp;
            row_written[chan][pos] = 1'b1;
            return;
        end
        warp_indices(pos, off, rcol, lcol);
        fv = $signed(off[7:0]);
        n = active_count();
        for (int c = 0; c < n; c++) begin
            rv = in_row(rcol) ? int'(row_mem[c][rcol[6:0]]) : 0;
            lv = in_row(lcol) ? int'(row_mem[c][lcol[6:0]]) : 0;
            total = rv * 256 + (lv - rv) * fv;
            res.chan = c[CHANNEL_W-1:0];
            res.pos = pos;
            res.value = total[15:8];
            res.last = (c == n - 1);
            pending_results.push_back(res);
        end
    endfunction

    // Offers one transaction, with a random gap at the start of each burst.
    task automatic send_item(input logic mode, input logic [CHANNEL_W-1:0] chan,
                             input logic [POSITION_W-1:0] pos,
                             input logic signed [SAMPLE_W-1:0] smp,
                             input logic [OFFSET_W-1:0] off);
        int gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(15, 30)
                                                     : $urandom_range(1, 8);
            gap = $urandom_range(0, 6);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        interpolate_item(mode, chan, pos, smp, off);
        s_valid    <= 1'b1;
        s_mode     <= mode;
        s_channel  <= chan;
        s_position <= pos;
        s_sample   <= smp;
        s_offset   <= off;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
    endtask

    // Loads any stored sample the warp will read that was never written, then sends the warp.
    task automatic send_warp(input logic [POSITION_W-1:0] pos, input logic [OFFSET_W-1:0] off);
        logic signed [SAMPLE_W-1:0] idx [2];
        warp_indices(pos, off, idx[0], idx[1]);
        for (int c = 0; c < active_count(); c++) begin
            foreach (idx[k]) begin
                if (in_row(idx[k]) && !row_written[c][idx[k][6:0]]) begin
                    send_item(MODE_LOAD, c[CHANNEL_W-1:0], idx[k][6:0], 8'($urandom),
                              16'($urandom));
                end
            end
        end
        send_item(MODE_WARP, 3'($urandom), pos, 8'($urandom), off);
        warps_sent++;
    endtask

    // Stops the sender until every expected sample is back and the block is quiet.
    task automatic wait_for_results();
        s_valid <= 1'b0;
        burst_left = 0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_register(input cfg_index_t idx, input logic [WIDTH_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        if (idx == CFG_CHANNEL_COUNT) begin
            chan_cfg = data[COUNT_W-1:0];
        end else begin
            width_cfg = data;
        end
        cfg_writes++;
    endtask

    // Registers at their reset values: one channel over the full row.
    task automatic test_default_registers();
        send_warp(7'd5, 16'h0040);
        send_warp(7'd5, 16'h01C0);
        send_item(MODE_LOAD, 3'd0, 7'd5, 8'sd99, 16'h1234);
        send_warp(7'd5, 16'h0000);
    endtask

    // Full-scale samples against extreme fractions and every index wrap.
    task automatic test_fraction_and_index_extremes();
        wait_for_results();
        write_register(CFG_CHANNEL_COUNT, 8'd2);
        send_item(MODE_LOAD, 3'd0, 7'd0,   8'h80, 16'h0000);
        send_item(MODE_LOAD, 3'd0, 7'd1,   8'h7F, 16'hFFFF);
        send_item(MODE_LOAD, 3'd0, 7'd126, 8'h7F, 16'h0000);
        send_item(MODE_LOAD, 3'd0, 7'd127, 8'h80, 16'hFFFF);
        send_item(MODE_LOAD, 3'd1, 7'd0,   8'h7F, 16'h0000);
        send_item(MODE_LOAD, 3'd1, 7'd1,   8'h80, 16'hFFFF);
        send_item(MODE_LOAD, 3'd1, 7'd126, 8'h80, 16'h0000);
        send_item(MODE_LOAD, 3'd1, 7'd127, 8'h7F, 16'hFFFF);
        send_warp(7'd1,   16'h0000);
        send_warp(7'd1,   16'h007F);
        send_warp(7'd1,   16'h0080);
        // Left index falls below zero.
        send_warp(7'd0,   16'h00FF);
        send_warp(7'd0,   16'h0140);
        // Right index wraps to -128 while the left one wraps to 127.
        send_warp(7'd0,   16'h8040);
        send_warp(7'd127, 16'hFFFF);
        send_warp(7'd127, 16'h7FFF);
        send_warp(7'd126, 16'hFF81);
        // Large positive difference wraps past the signed range.
        send_warp(7'd100, 16'h9C30);
    endtask

    // Channel count of zero and above eight, row widths of 0, 1, 255 and 128.
    task automatic test_register_extremes();
        wait_for_results();
        write_register(CFG_CHANNEL_COUNT, 8'd0);
        send_warp(7'd3, 16'h0010);
        send_warp(7'($urandom), 16'($urandom));
        wait_for_results();
        write_register(CFG_CHANNEL_COUNT, 8'd15);
        write_register(CFG_ROW_WIDTH, 8'd1);
        send_warp(7'd1, 16'h0040);
        send_warp(7'd0, 16'h00C0);
        wait_for_results();
        write_register(CFG_ROW_WIDTH, 8'd0);
        send_warp(7'd3, 16'h0155);
        wait_for_results();
        write_register(CFG_ROW_WIDTH, 8'd255);
        send_warp(7'd127, 16'h0080);
        wait_for_results();
        write_register(CFG_ROW_WIDTH, 8'd128);
        write_register(CFG_CHANNEL_COUNT, 8'd8);
        send_warp(7'd64, 16'h0020);
    endtask

    // Receiver holds off for a long stretch while warps keep arriving.
    task automatic test_output_stall();
        logic [POSITION_W-1:0] base;
        wait_for_results();
        base = 7'($urandom);
        hold_request++;
        repeat (16) send_warp(base + 7'($urandom_range(0, 3)), 16'($urandom_range(0, 255)));
        wait_for_results();
    endtask

    // Random traffic over a set of register settings, mostly in one window of columns.
    task automatic test_random_phases();
        int phase_end;
        int pick;
        logic [POSITION_W-1:0] win_base;
        logic [POSITION_W-1:0] pos;
        logic [OFFSET_W-1:0]   off;
        win_base = 7'($urandom);
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            wait_for_results();
            pick = $urandom_range(0, 9);
            write_register(CFG_CHANNEL_COUNT,
                           (pick == 0) ? 8'd0 :
                           (pick == 1) ? 8'($urandom_range(9, 15)) : 8'($urandom_range(1, 8)));
            pick = $urandom_range(0, 9);
            write_register(CFG_ROW_WIDTH,
                           (pick == 0) ? 8'd0 :
                           (pick == 1) ? 8'($urandom_range(129, 255)) :
                           (pick <= 3) ? 8'd128 : 8'($urandom_range(1, 127)));
            phase_end = items_sent + ITEMS_PER_PHASE;
            while (items_sent < phase_end) begin
                pos = ($urandom_range(0, 3) != 0) ? win_base + 7'($urandom_range(0, 9))
                                                  : 7'($urandom);
                if ($urandom_range(0, 3) == 0) begin
                    send_item(MODE_LOAD, 3'($urandom), pos, 8'($urandom), 16'($urandom));
                end else if ($urandom_range(0, 7) == 0) begin
                    send_warp(pos, 16'($urandom));
                end else begin
                    off = {8'($urandom_range(0, 10) - 5), 8'($urandom)};
                    send_warp(pos, off);
                end
            end
        end
    endtask

    // Compares each accepted transaction with the oldest expected sample.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result: out_channel %0d out_position %0d value %0d last %0b",
                       m_out_channel, m_out_position, m_value, m_last);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                results_seen++;
                if (m_out_channel !== want.chan) begin
                    $error("out_channel mismatch: expected %0d, actual %0d",
                           want.chan, m_out_channel);
                    error_count++;
                end
                if (m_out_position !== want.pos) begin
                    $error("out_position mismatch: expected %0d, actual %0d",
                           want.pos, m_out_position);
                    error_count++;
                end
                if (m_value !== want.value) begin
                    $error("value mismatch: expected %0d, actual %0d", want.value, m_value);
                    error_count++;
                end
                if (m_last !== want.last) begin
                    $error("last mismatch: expected %0b, actual %0b", want.last, m_last);
                    error_count++;
                end
            end
        end
    end

    // Receiver alternates stretches of full readiness with light and heavy stalling.
    initial begin
        int run_len;
        int run_kind;
        m_ready = 1'b0;
        hold_served = 0;
        forever begin
            run_len = $urandom_range(1, 40);
            run_kind = $urandom_range(0, 2);
            repeat (run_len) begin
                @(posedge aclk);
                if (hold_request != hold_served) begin
                    hold_served = hold_request;
                    m_ready <= 1'b0;
                    repeat (HOLD_CYCLES) @(posedge aclk);
                end
                case (run_kind)
                    0: begin
                        m_ready <= 1'b1;
                    end
                    1: begin
                        m_ready <= ($urandom_range(0, 3) != 0);
                    end
                    default: begin
                        m_ready <= ($urandom_range(0, 1) == 1);
                    end
                endcase
            end
        end
    end

    initial begin
        #(TIMEOUT_NS);
        $error("timeout with %0d results still expected", pending_results.size());
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        aclk       = 1'b0;
        aresetn    = 1'b0;
        s_valid    = 1'b0;
        s_mode     = MODE_LOAD;
        s_channel  = '0;
        s_position = '0;
        s_sample   = '0;
        s_offset   = '0;
        cfg_wr_en  = 1'b0;
        cfg_index  = CFG_CHANNEL_COUNT;
        cfg_data   = '0;
        chan_cfg   = 1;
        width_cfg  = 128;
        burst_left = 0;
        items_sent = 0;
        warps_sent = 0;
        cfg_writes = 0;
        results_seen = 0;
        error_count = 0;
        hold_request = 0;
        foreach (row_written[c, p]) row_written[c][p] = 1'b0;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        test_default_registers();
        test_fraction_and_index_extremes();
        test_register_extremes();
        test_output_stall();
        test_random_phases();
        wait_for_results();

        $display("Sent %0d transactions, %0d of them warps, across %0d register writes.",
                 items_sent, warps_sent, cfg_writes);
        $display("Checked %0d interpolated samples with %0d mismatches.",
                 results_seen, error_count);
        if (error_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
